@@ design/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with key search.
// ----------------------------------------------------------------------------
package deq_pkg;

   // default store depth
   localparam int DEPTH_DEFAULT = 16;
   // entries in the command queue between front and back parts
   localparam int CMD_QUEUE_DEPTH = 2;

   // fixed payload widths
   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request codes on the input channel
   localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_PEEK_FRONT = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_SEARCH     = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_CLEAR      = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // decoded operation
   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_PEEK_FRONT,
      OP_SEARCH,
      OP_CLEAR,
      OP_NOP
   } op_type;

   // command handed from front part to back part
   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   // back part execution state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEARCH
   } back_state_type;

endpackage : deq_pkg
`default_nettype wire

@@ design/deq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_front
// Accepts request transactions and classifies them into commands, one
// register stage ahead of the command queue.
// ----------------------------------------------------------------------------
module deq_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [deq_pkg::TYPE_W-1:0]  req_type,
   input  wire logic [deq_pkg::VALUE_W-1:0] req_item_value,
   output logic                          cmd_valid,
   input  wire logic                     cmd_ready,
   output deq_pkg::cmd_type              cmd
);
   import deq_pkg::*;

   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   op_type  op_dec;

   // request code to operation
   always_comb begin
      case (req_type)
         REQ_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
         REQ_PUSH_BACK:  op_dec = OP_PUSH_BACK;
         REQ_POP_FRONT:  op_dec = OP_POP_FRONT;
         REQ_POP_BACK:   op_dec = OP_POP_BACK;
         REQ_PEEK_FRONT: op_dec = OP_PEEK_FRONT;
         REQ_SEARCH:     op_dec = OP_SEARCH;
         REQ_CLEAR:      op_dec = OP_CLEAR;
         default:        op_dec = OP_NOP;
      endcase
   end

   // stage register takes a new transaction when empty or draining
   always_comb begin
      req_ready = !vld_ff || cmd_ready;
      vld_in    = vld_ff && !cmd_ready;
      cmd_in    = cmd_ff;
      if (req_valid && req_ready) begin
         vld_in       = 1'b1;
         cmd_in.op    = op_dec;
         cmd_in.value = req_item_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = vld_ff;
   assign cmd       = cmd_ff;

endmodule : deq_front
`default_nettype wire

@@ design/deq_cmd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_cmd_queue
// Short first-in first-out queue of commands between the front and back
// parts.
// ----------------------------------------------------------------------------
module deq_cmd_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  deq_pkg::cmd_type in_cmd,
   output logic            out_valid,
   input  wire logic       out_ready,
   output deq_pkg::cmd_type out_cmd
);
   import deq_pkg::*;

   localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type         entry_ff [CMD_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   fill_ff, fill_in;
   logic            push, pop;

   assign in_ready  = (fill_ff != NW'(CMD_QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule : deq_cmd_queue
`default_nettype wire

@@ design/deq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_back
// Carries out commands on the ring store and holds the result register.
// Search walks the held entries one read per cycle.
// ----------------------------------------------------------------------------
module deq_back #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cmd_valid,
   output logic                              cmd_ready,
   input  deq_pkg::cmd_type                  cmd,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [deq_pkg::VALUE_W-1:0]       rsp_result_data,
   output logic                              rsp_key_found,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                              rsp_is_empty
);
   import deq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   // ring store, undefined until written
   logic [VALUE_W-1:0] mem [DEPTH];

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               wr_en, rd_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [IW-1:0]      front_dec, front_inc, ptr_inc, back_slot, last_slot;
   logic [SW-1:0]      back_sum, last_sum;
   logic [CW+COUNT_W-1:0] count_ext;
   logic               is_full, is_none, done;

   // ring index arithmetic with wrap at DEPTH
   always_comb begin
      front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - 1'b1;
      front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
      ptr_inc   = (ptr_ff == IW'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      back_sum  = SW'(front_ff) + SW'(count_ff);
      last_sum  = back_sum - 1'b1;
      back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
      last_slot = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);
      is_full   = (count_ff == CW'(DEPTH));
      is_none   = (count_ff == '0);
   end

   // next state, store access and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      wr_data       = cmd.value;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      cmd_ready     = 1'b0;
      done          = 1'b1;
      count_ext     = '0;

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = !rsp_valid_ff || rsp_ready;
            if (cmd_valid && cmd_ready) begin
               rsp_data_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STATUS_OK;
               case (cmd.op)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        front_in = front_dec;
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_slot;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_none) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        count_in = count_ff - 1'b1;
                        front_in = (count_ff == CW'(1)) ? '0 : front_inc;
                        done     = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_none) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_slot;
                        count_in = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           front_in = '0;
                        end
                        done     = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  OP_PEEK_FRONT: begin
                     if (is_none) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        done     = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  OP_SEARCH: begin
                     if (!is_none) begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        ptr_in   = front_inc;
                        left_in  = count_ff - 1'b1;
                        key_in   = cmd.value;
                        done     = 1'b0;
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     front_in = '0;
                  end
                  default: begin
                  end
               endcase
               // count and empty flag reflect the state after this command
               count_ext    = (CW + COUNT_W)'(count_in);
               rsp_count_in = count_ext[COUNT_W-1:0];
               rsp_empty_in = (count_in == '0);
               if (done) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_data_in  = rd_data_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEARCH: begin
            // compare the entry read last cycle, issue the next read
            if (rd_data_ff == key_ff) begin
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff;
               ptr_in  = ptr_inc;
               left_in = left_ff - 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      key_ff        <= key_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // ring store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_data = rsp_data_ff;
   assign rsp_key_found   = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   // held count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count above depth");

   // an empty queue always restarts at slot zero
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> front_ff == '0)
      else $error("front index not zero while empty");

   // no result shown while a read or search is in flight
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("result valid during multi-cycle command");

   // a full status is only reported with the store full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> count_ff == CW'(DEPTH))
      else $error("full status without full store");

   // a front pop leaves the state one entry smaller
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && $past(cmd.op) == OP_POP_FRONT
      |-> count_ff == $past(count_ff) - 1'b1)
      else $error("count not reduced by pop");
`endif

endmodule : deq_back
`default_nettype wire

@@ design/double_ended_queue_with_search_core.sv @@
// Throughput: one push or clear per cycle while each result is taken; a pop or
//   peek waits in a read state and a search walks the held entries through the
//   single read port of the ring store, and no new command is taken meanwhile.
// Reset: synchronous, clears the queue to empty and drops queued requests;
//   store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_core
// Bounded double-ended queue of signed 32-bit values with key search: a front
// part classifies requests, a command queue decouples it from the back part
// that runs the ring store.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_core #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [deq_pkg::TYPE_W-1:0]    req_type,
   input  wire logic signed [deq_pkg::VALUE_W-1:0] req_item_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [deq_pkg::VALUE_W-1:0] rsp_result_data,
   output logic                               rsp_key_found,
   output logic [deq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                               rsp_is_empty
);
   import deq_pkg::*;

   logic               front_valid, front_ready;
   cmd_type            front_cmd;
   logic               queue_valid, queue_ready;
   cmd_type            queue_cmd;
   logic [VALUE_W-1:0] result_data;

   // classify incoming transactions
   deq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   // decoupling queue
   deq_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   // execute on the ring store
   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (queue_valid),
      .cmd_ready       (queue_ready),
      .cmd             (queue_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_data (result_data),
      .rsp_key_found   (rsp_key_found),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   assign rsp_result_data = $signed(result_data);

endmodule : double_ended_queue_with_search_core
`default_nettype wire
